// File: hdl/mf3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

	localparam int PIX_W     = 8;
	localparam int MAX_W     = 1024;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 16;
	localparam int OIDX_W    = 26;
	localparam int WID_W     = 11;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WID_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [ROW_W-1:0] RESET_HEIGHT = 16'd480;
	localparam logic [ROW_W-1:0] ROW_LAST     = 16'hFFFF;

	localparam logic REQ_PIXEL = 1'b0;

	typedef logic [PIX_W-1:0] pix_t;

	// per-beat control carried down the pipe
	typedef struct packed {
		logic emit;
		logic use_med;
		logic last;
	} stage_ctrl_t;

endpackage

// File: hdl/mf3_if.sv
`timescale 1ns / 1ps
// Stream interfaces for pixel requests and filtered results.
interface mf3_req_if;
	logic           valid;
	logic           ready;
	logic           req_type;
	mf3_pkg::pix_t  pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface mf3_res_if;
	logic           valid;
	logic           ready;
	mf3_pkg::pix_t  pixel_out;
	logic           last_pixel;

	modport source (output valid, output pixel_out, output last_pixel, input ready);
	modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// File: hdl/median_filter_3x3_top.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 median filter.
//
// Channels: "stream" takes request beats (req_type 0 = pixel in raster order,
// 1 = drain tick); "result" gives filtered pixels in raster order. Both use
// valid/ready; a beat moves on a rising edge with valid and ready high.
// Config: cfg_we/cfg_index/cfg_data write image_width (0) and image_height (1);
// the host must write only while the filter is idle; not enforced here.
// Image-level delay: the first width+1 beats of an image give no result; after
// that each beat gives one result until width*height results are out. The host
// follows the image with width+1 drain ticks. last_pixel marks the final one.
// Throughput: one beat per clock while the receiver keeps up. Each result passes
// through line-store read (s1), window shift (s2) and median into the output
// register.
// Reset clears counters, window and pipe valids; the line stores are not
// cleared, whatever they hold before the first rows land only reaches border
// outputs, and those are forced to zero.
// When the receiver stalls the output register holds its beat and the two
// inner stages keep filling; stream.ready drops only once every stage is full.
module median_filter_3x3_top (
	input  logic                               clk,
	input  logic                               arst_n,
	mf3_req_if.sink                            stream,
	mf3_res_if.source                          result,
	input  logic                               cfg_we,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mf3_pkg::CFG_W-1:0]          cfg_data
);

	// ---------------- configuration ----------------
	// registers keep the clamped geometry: width 1..MAX_W, height at least 1
	logic [mf3_pkg::WID_W-1:0]  w_eff_q;
	logic [mf3_pkg::ROW_W-1:0]  h_eff_q;
	logic [mf3_pkg::WID_W-1:0]  w_nxt;
	logic [mf3_pkg::ROW_W-1:0]  h_nxt;
	logic [mf3_pkg::WID_W-1:0]  wid_in;
	logic [mf3_pkg::ROW_W-1:0]  hgt_in;
	logic [mf3_pkg::OIDX_W-1:0] total_q;
	logic [mf3_pkg::WID_W+mf3_pkg::ROW_W-1:0] total_full;

	assign wid_in = cfg_data[mf3_pkg::WID_W-1:0];
	assign hgt_in = cfg_data[mf3_pkg::ROW_W-1:0];

	always_comb begin
		w_nxt = w_eff_q;
		h_nxt = h_eff_q;
		if (cfg_we) begin
			case (cfg_index)
				mf3_pkg::REG_IMAGE_WIDTH: begin
					if (wid_in == '0)
						w_nxt = mf3_pkg::WID_W'(1);
					else if (wid_in > mf3_pkg::WID_W'(mf3_pkg::MAX_W))
						w_nxt = mf3_pkg::WID_W'(mf3_pkg::MAX_W);
					else
						w_nxt = wid_in;
				end
				mf3_pkg::REG_IMAGE_HEIGHT: begin
					h_nxt = (hgt_in == '0) ? mf3_pkg::ROW_W'(1) : hgt_in;
				end
				default: ;
			endcase
		end
	end

	// pixel count of the image, updated on the same edge as the geometry
	assign total_full = w_nxt * h_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= mf3_pkg::RESET_WIDTH;
			h_eff_q <= mf3_pkg::RESET_HEIGHT;
			total_q <= mf3_pkg::OIDX_W'(mf3_pkg::RESET_WIDTH) *
			           mf3_pkg::OIDX_W'(mf3_pkg::RESET_HEIGHT);
		end else begin
			w_eff_q <= w_nxt;
			h_eff_q <= h_nxt;
			total_q <= total_full[mf3_pkg::OIDX_W-1:0];
		end
	end

	// ---------------- pipe handshake ----------------
	logic valid_s1, valid_s2, out_valid_q;
	mf3_pkg::stage_ctrl_t ctrl_s1, ctrl_s2;
	logic free_o, go1, go2, en1, en2, accept;

	assign free_o = !out_valid_q || result.ready;
	assign go2    = valid_s2 && (free_o || !ctrl_s2.emit);
	assign en2    = !valid_s2 || go2;
	assign go1    = valid_s1 && en2;
	assign en1    = !valid_s1 || go1;
	assign stream.ready = en1;
	assign accept = stream.valid && en1;

	// ---------------- position counters ----------------
	logic [mf3_pkg::COL_W-1:0]  col_q;
	logic [mf3_pkg::ROW_W-1:0]  row_q;
	logic [mf3_pkg::OIDX_W-1:0] oidx_q;
	logic [mf3_pkg::WID_W-1:0]  col_ext, col_inc;
	mf3_pkg::stage_ctrl_t       ctrl_new;
	logic                       warm;
	mf3_pkg::pix_t              px_new;

	assign col_ext = {1'b0, col_q};
	assign col_inc = col_ext + mf3_pkg::WID_W'(1);
	assign px_new  = (stream.req_type == mf3_pkg::REQ_PIXEL) ? stream.pixel_in : '0;

	always_comb begin
		warm = (row_q >= mf3_pkg::ROW_W'(2)) ||
		       (row_q == mf3_pkg::ROW_W'(1) && col_q != '0);
		ctrl_new.emit    = warm && (oidx_q < total_q);
		// interior center only; borders give zero
		ctrl_new.use_med = (col_q >= mf3_pkg::COL_W'(2)) && (row_q >= mf3_pkg::ROW_W'(2)) &&
		                   (row_q < h_eff_q) && (col_ext < w_eff_q);
		ctrl_new.last    = (oidx_q + mf3_pkg::OIDX_W'(1)) == total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			oidx_q <= '0;
		end else if (accept) begin
			if (ctrl_new.emit && ctrl_new.last) begin
				// image done, start over
				col_q  <= '0;
				row_q  <= '0;
				oidx_q <= '0;
			end else begin
				if (ctrl_new.emit)
					oidx_q <= oidx_q + mf3_pkg::OIDX_W'(1);
				if (col_inc >= w_eff_q) begin
					col_q <= '0;
					if (row_q != mf3_pkg::ROW_LAST)
						row_q <= row_q + mf3_pkg::ROW_W'(1);
				end else begin
					col_q <= col_inc[mf3_pkg::COL_W-1:0];
				end
			end
		end
	end

	// ---------------- line stores: {upper, lower} per column ----------------
	logic [2*mf3_pkg::PIX_W-1:0] line_mem [mf3_pkg::MAX_W];
	logic [2*mf3_pkg::PIX_W-1:0] rd_s1;
	logic [mf3_pkg::COL_W-1:0]   col_s1;
	mf3_pkg::pix_t               px_s1;

	// read on accept, write back (upper <- old lower, lower <- pixel) as s1 leaves
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= line_mem[col_q];
		if (go1)
			line_mem[col_s1] <= {rd_s1[mf3_pkg::PIX_W-1:0], px_s1};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_q;
			px_s1   <= px_new;
			ctrl_s1 <= ctrl_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en1)
			valid_s1 <= stream.valid;
	end

	// ---------------- window: index r*3+c, r=0 oldest row, c=0 oldest col ----
	mf3_pkg::pix_t window_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				window_q[i] <= '0;
		end else if (go1) begin
			for (int r = 0; r < 3; r++) begin
				window_q[3*r]   <= window_q[3*r+1];
				window_q[3*r+1] <= window_q[3*r+2];
			end
			window_q[2] <= rd_s1[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
			window_q[5] <= rd_s1[mf3_pkg::PIX_W-1:0];
			window_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go1)
			ctrl_s2 <= ctrl_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en2)
			valid_s2 <= valid_s1;
	end

	// ---------------- median and output register ----------------
	mf3_pkg::pix_t med;
	mf3_pkg::pix_t pix_q;
	logic          last_q;

	mf3_median u_median (
		.win (window_q),
		.med (med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (go2 && ctrl_s2.emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go2 && ctrl_s2.emit) begin
			pix_q  <= ctrl_s2.use_med ? med : '0;
			last_q <= ctrl_s2.last;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pixel_out  = pix_q;
	assign result.last_pixel = last_q;

endmodule

// File: hdl/mf3_median.sv
`timescale 1ns / 1ps
// Median of nine pixels: sort each triple, then median of max-low, mid-mid, min-high.
module mf3_median (
	input  mf3_pkg::pix_t win [9],
	output mf3_pkg::pix_t med
);

	function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
			input mf3_pkg::pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	mf3_pkg::pix_t lo [3];
	mf3_pkg::pix_t mi [3];
	mf3_pkg::pix_t hi [3];

	always_comb begin
		for (int g = 0; g < 3; g++) begin
			lo[g] = min2(min2(win[3*g], win[3*g+1]), win[3*g+2]);
			hi[g] = max2(max2(win[3*g], win[3*g+1]), win[3*g+2]);
			mi[g] = med3(win[3*g], win[3*g+1], win[3*g+2]);
		end
	end

	assign med = med3(max2(max2(lo[0], lo[1]), lo[2]),
	                  med3(mi[0], mi[1], mi[2]),
	                  min2(min2(hi[0], hi[1]), hi[2]));

endmodule

// File: hdl/mf3_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the median filter, bound to the top level.
module mf3_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input mf3_pkg::pix_t       pixel_out,
	input logic                last_pixel
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// and keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_out) && $stable(last_pixel))
		else $error("result payload changed while stalled");

	// a free output register means the pipe can always take a beat
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("stream not ready with output free");

	// the last pixel is a corner, so it is always zero
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_out == '0)
		else $error("last pixel not zero");

	// ready is always known while a beat is offered
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_ready))
		else $error("stream ready unknown");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (stream.valid),
	.in_ready   (stream.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.pixel_out  (result.pixel_out),
	.last_pixel (result.last_pixel)
);

// File: test/median_filter_3x3_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 median filter top level.
module median_filter_3x3_top_tb;

	// drain tick code: the request type that is not a pixel
	localparam logic REQ_DRAIN   = ~mf3_pkg::REQ_PIXEL;
	localparam int   MEDIAN_RANK = 4;           // rank 4 of 9 is the median
	localparam int   RAND_BEATS  = 1925;        // target size of the random part
	localparam int   SETTLE_CYC  = 8;           // two-stage pipe plus output reg, with margin
	localparam int   REPORT_MAX  = 10;
	// timeout guard for a full run, even with the heaviest back-pressure
	localparam int   CYCLE_LIMIT = 50_000;

	typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_CLUSTER} pix_mode_t;

	typedef struct {
		logic          kind;
		mf3_pkg::pix_t value;
	} filt_req_t;

	typedef struct {
		mf3_pkg::pix_t pixel;
		logic          last_px;
	} filt_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mf3_pkg::CFG_W-1:0]     cfg_data;

	mf3_req_if req_ch ();
	mf3_res_if res_ch ();

	median_filter_3x3_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (req_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------------
	// Filter predictor state: our own copy of geometry, line stores, window
	// and raster counters. Line stores start at zero here; the block leaves
	// them undefined, but no output ever depends on an unwritten entry.
	// ---------------------------------------------------------------------
	logic [mf3_pkg::WID_W-1:0] width_reg;
	logic [mf3_pkg::ROW_W-1:0] height_reg;
	mf3_pkg::pix_t    upper_line [mf3_pkg::MAX_W];
	mf3_pkg::pix_t    lower_line [mf3_pkg::MAX_W];
	mf3_pkg::pix_t    win_px [9];      // [row*3 + col], row 0 / col 0 oldest
	int unsigned      col_pos;
	int unsigned      row_pos;
	int unsigned      emitted;         // outputs given so far in this image

	filt_req_t        pending_req [$]; // beats waiting for the driver
	filt_result_t     expected_px [$]; // filtered pixels not yet seen

	logic             req_beat_taken;
	int               src_idle_pct;
	int               snk_idle_pct;
	int               mismatches;
	int               beats_in;
	int               results_seen;
	int               images;
	int               cycle_count;

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > mf3_pkg::MAX_W)
			return mf3_pkg::MAX_W;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : 32'(height_reg);
	endfunction

	// Advance the predictor by one request beat; returns 1 when the beat
	// produces a filtered pixel.
	function automatic bit predict_beat(input logic kind, input mf3_pkg::pix_t raw,
			output mf3_pkg::pix_t filt, output logic last_px);
		int unsigned   w, h, total, c, r;
		mf3_pkg::pix_t px, up, lo, key;
		mf3_pkg::pix_t v [9];
		int            j;
		bit            emit;
		w     = eff_width();
		h     = eff_height();
		total = w * h;
		c     = col_pos;
		r     = row_pos;
		emit  = 1'b0;
		filt  = '0;
		last_px = 1'b0;
		// a drain tick inside the image counts as a black pixel
		px = (kind == mf3_pkg::REQ_PIXEL) ? raw : '0;

		up = upper_line[c];
		lo = lower_line[c];
		upper_line[c] = lo;
		lower_line[c] = px;
		for (int k = 0; k < 3; k++) begin
			win_px[3*k]   = win_px[3*k+1];
			win_px[3*k+1] = win_px[3*k+2];
		end
		win_px[2] = up;
		win_px[5] = lo;
		win_px[8] = px;

		// warm-up: nothing leaves until one row plus one pixel is in
		if (((r >= 2) || (r == 1 && c >= 1)) && emitted < total) begin
			// centre is (r-1, c-1); borders and tiny images stay 0
			if (c >= 2 && r >= 2 && r + 1 <= h && c + 1 <= w) begin
				v = win_px;
				for (int i = 1; i < 9; i++) begin
					key = v[i];
					j   = i - 1;
					while (j >= 0 && v[j] > key) begin
						v[j+1] = v[j];
						j--;
					end
					v[j+1] = key;
				end
				filt = v[MEDIAN_RANK];
			end
			last_px = (emitted + 1 == total);
			emitted++;
			emit = 1'b1;
			// image end: counters snap back, next beat starts a new image
			if (emitted >= total) begin
				col_pos = 0;
				row_pos = 0;
				emitted = 0;
				return emit;
			end
		end

		if (c + 1 >= w) begin
			col_pos = 0;
			// row counter saturates rather than wrapping
			if (row_pos < mf3_pkg::ROW_LAST)
				row_pos++;
		end else begin
			col_pos = c + 1;
		end
		return emit;
	endfunction

	function automatic mf3_pkg::pix_t draw_pixel(pix_mode_t mode, mf3_pkg::pix_t base);
		case (mode)
			PIX_BINARY: begin
				return $urandom_range(1) ? 8'hFF : 8'h00;
			end
			PIX_CLUSTER: begin
				// tight spread forces lots of ties in the sort
				return base + mf3_pkg::pix_t'($urandom_range(3));
			end
			default: begin
				return mf3_pkg::pix_t'($urandom_range(255));
			end
		endcase
	endfunction

	// Queue one whole image plus its drain ticks for the current geometry.
	// inner_drain_pct puts drain ticks inside the image; tail_pixel_pct puts
	// pixels where drain ticks belong. Returns the number of beats queued.
	function automatic int queue_image(pix_mode_t mode, int inner_drain_pct,
			int tail_pixel_pct);
		int unsigned   w, h;
		mf3_pkg::pix_t base;
		filt_req_t     b;
		w    = eff_width();
		h    = eff_height();
		base = mf3_pkg::pix_t'($urandom_range(255));
		repeat (w * h) begin
			b.kind  = ($urandom_range(99) < inner_drain_pct) ? REQ_DRAIN : mf3_pkg::REQ_PIXEL;
			b.value = draw_pixel(mode, base);
			pending_req = {pending_req, b};
		end
		repeat (w + 1) begin
			b.kind  = ($urandom_range(99) < tail_pixel_pct) ? mf3_pkg::REQ_PIXEL : REQ_DRAIN;
			b.value = mf3_pkg::pix_t'($urandom_range(255));   // junk payload on drains
			pending_req = {pending_req, b};
		end
		images++;
		return w * h + w + 1;
	endfunction

	task automatic push_beat(input logic kind, input mf3_pkg::pix_t value);
		filt_req_t b;
		b.kind  = kind;
		b.value = value;
		pending_req = {pending_req, b};
	endtask

	// Block is idle once every queued beat is in and every result is out.
	// Each image ends on a result, so a short settle is all that is left.
	task automatic wait_until_drained();
		while (pending_req.size() != 0 || req_ch.valid || expected_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mf3_pkg::CFG_IDX_W-1:0] idx,
			input logic [mf3_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_geometry(input int unsigned w_reg, input int unsigned h_reg);
		wait_until_drained();
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, mf3_pkg::CFG_W'(w_reg));
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, mf3_pkg::CFG_W'(h_reg));
		width_reg  = w_reg[mf3_pkg::WID_W-1:0];
		height_reg = h_reg[mf3_pkg::ROW_W-1:0];
	endtask

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still outstanding",
				cycle_count, expected_px.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Request driver: changes on the falling edge. A beat offered stays put
	// until the rising edge that takes it.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin : req_driver
		filt_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_beat_taken) begin
			if (pending_req.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pending_req.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.req_type <= nxt.kind;
				req_ch.pixel_in <= nxt.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, fresh every cycle
	always @(negedge clk)
		res_ch.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);

	// ---------------------------------------------------------------------
	// Monitor: checks result beats against the oldest prediction, then feeds
	// accepted request beats to the predictor. Results trail their requests through
	// the registered pipe stages, so the order of the two halves does not matter.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		filt_result_t  want;
		mf3_pkg::pix_t p;
		logic          l;
		if (!arst_n) begin
			req_beat_taken <= 1'b0;
		end else begin
			req_beat_taken <= req_ch.valid && req_ch.ready;

			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_px.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("[%0t] unexpected result beat: pixel_out=%0d last_pixel=%0b",
							$time, res_ch.pixel_out, res_ch.last_pixel);
				end else begin
					want = expected_px.pop_front();
					if (res_ch.pixel_out !== want.pixel ||
					    res_ch.last_pixel !== want.last_px) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"[%0t] result %0d: expected pixel_out=%0d ",
								"last_pixel=%0b, got pixel_out=%0d last_pixel=%0b"},
								$time, results_seen, want.pixel, want.last_px,
								res_ch.pixel_out, res_ch.last_pixel);
					end
				end
			end

			if (req_ch.valid && req_ch.ready) begin
				beats_in++;
				if (predict_beat(req_ch.req_type, req_ch.pixel_in, p, l)) begin
					want.pixel   = p;
					want.last_px = l;
					expected_px = {expected_px, want};
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin : stimulus
		int          random_beats;
		int unsigned sel;
		int unsigned w_reg;
		int unsigned h_reg;
		pix_mode_t   mode;

		// every input known from time zero
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = mf3_pkg::REQ_PIXEL;
		req_ch.pixel_in = '0;
		res_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = mf3_pkg::REG_IMAGE_WIDTH;
		cfg_data        = '0;
		src_idle_pct    = 26;
		snk_idle_pct    = 46;
		mismatches      = 0;
		beats_in        = 0;
		results_seen    = 0;
		images          = 0;
		cycle_count     = 0;
		random_beats    = 0;

		width_reg  = mf3_pkg::RESET_WIDTH;
		height_reg = mf3_pkg::RESET_HEIGHT;
		col_pos    = 0;
		row_pos    = 0;
		emitted    = 0;
		foreach (win_px[i])
			win_px[i] = '0;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// 3x3: one interior pixel, median 255 with 0 and 255 extremes around it;
		// the second beat is a drain tick inside the image (counts as 0)
		set_geometry(3, 3);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd255);
		push_beat(REQ_DRAIN, 8'd77);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd255);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd0);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd255);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd255);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd128);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd0);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd255);
		push_beat(REQ_DRAIN, 8'd0);
		push_beat(REQ_DRAIN, 8'd0);
		push_beat(REQ_DRAIN, 8'd0);
		push_beat(REQ_DRAIN, 8'd255);
		images++;

		// 2x2 is too small for any interior pixel; pixels replace drain ticks
		set_geometry(2, 2);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd1);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd2);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd3);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd4);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd255);
		push_beat(REQ_DRAIN, 8'd0);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd0);
		images++;

		// zero in both registers clamps to a 1x1 image
		set_geometry(0, 0);
		push_beat(mf3_pkg::REQ_PIXEL, 8'd200);
		push_beat(REQ_DRAIN, 8'd0);
		push_beat(REQ_DRAIN, 8'd0);
		images++;

		// --- random images ---
		// mostly clean images; some with drains inside, some with pixels in
		// the drain tail. About 40% reuse the geometry back to back.
		while (random_beats < RAND_BEATS) begin
			case (random_beats * 3 / RAND_BEATS)
				0: begin
					src_idle_pct = 26;
					snk_idle_pct = 46;
				end
				1: begin
					src_idle_pct = 46;
					snk_idle_pct = 26;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase

			if ($urandom_range(99) < 60) begin
				sel   = $urandom_range(99);
				w_reg = (sel < 5)  ? 0 :
					(sel < 15) ? $urandom_range(2, 1) :
					(sel < 88) ? $urandom_range(12, 3) : $urandom_range(48, 13);
				sel   = $urandom_range(99);
				h_reg = (sel < 5)  ? 0 :
					(sel < 15) ? $urandom_range(2, 1) :
					(sel < 90) ? $urandom_range(8, 3) : $urandom_range(20, 9);
				set_geometry(w_reg, h_reg);
			end

			mode = pix_mode_t'($urandom_range(2));
			sel  = $urandom_range(99);
			if (sel < 70)
				random_beats += queue_image(mode, 0, 0);
			else if (sel < 85)
				random_beats += queue_image(mode, 10, 0);
			else
				random_beats += queue_image(mode, 0, 50);
		end

		wait_until_drained();

		$display("%0d request beats in %0d images, %0d filtered pixels checked, %0d mismatches",
			beats_in, images, results_seen, mismatches);
		$display("geometries from 1x1 up to 48x20 incl. zero registers, three back-pressure mixes");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
